FILE: rtl/accel_follow_and_polar_peak_hold_defines.svh
// assertion macros
`ifndef ACCEL_FOLLOW_AND_POLAR_PEAK_HOLD_DEFINES_SVH
`define ACCEL_FOLLOW_AND_POLAR_PEAK_HOLD_DEFINES_SVH
`ifndef SYNTHESIS
`define AFP_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define AFP_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AFP_ASSERT_IMPL(label, clk, rst_n, a, c)
`define AFP_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/afp_pkg.sv
package afp_pkg;
  localparam int BINS = 32;
  localparam int BIN_W = $clog2(BINS);
  localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(BINS - 1);
  localparam int RAD_W = 13;
  localparam int CORDIC_STEPS = 16;
  localparam logic [14:0] MAX_G_RST = 15'd8192;
  localparam logic [15:0] DEADZONE_Q = 16'd62;
  localparam logic [33:0] D2_HIGH = 34'd2684354;
  localparam logic [33:0] D2_MID = 34'd671088;
  localparam logic [15:0] FOLLOW_LOW = 16'd9175;
  localparam logic [15:0] FOLLOW_MID = 16'd15729;
  localparam logic [15:0] FOLLOW_HIGH = 16'd22282;
  localparam logic [12:0] R_MIN = 13'd40;
  localparam logic [12:0] R_ONE = 13'd4096;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] ADDR_MAX_G = 2'd0;

  typedef struct packed {
    logic [1:0] req_type;
    logic signed [15:0] lat_g;
    logic signed [15:0] lon_g;
    logic [4:0] read_bin;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] display_lat;
    logic signed [15:0] display_lon;
    logic [4:0] bin_slot;
    logic [12:0] bin_radius;
    logic bin_updated;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic [16:0] mg;
    logic [16:0] lat;
    logic [16:0] lon;
  } geo_req_t;

  typedef struct packed {
    logic done;
    logic [12:0] radius;
    logic [BIN_W-1:0] bin;
  } geo_rsp_t;

  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0: v = 32'h20000000;
      4'd1: v = 32'h12E4051E;
      4'd2: v = 32'h09FB385B;
      4'd3: v = 32'h051111D4;
      4'd4: v = 32'h028B0D43;
      4'd5: v = 32'h0145D7E1;
      4'd6: v = 32'h00A2F61E;
      4'd7: v = 32'h00517C55;
      4'd8: v = 32'h0028BE53;
      4'd9: v = 32'h00145F2F;
      4'd10: v = 32'h000A2F98;
      4'd11: v = 32'h000517CC;
      4'd12: v = 32'h00028BE6;
      4'd13: v = 32'h000145F3;
      4'd14: v = 32'h0000A2FA;
      4'd15: v = 32'h0000517D;
      default: v = 32'h0;
    endcase
    return v;
  endfunction
endpackage

FILE: rtl/afp_ram.sv
module afp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/afp_geom.sv
module afp_geom (
  input  logic              clk,
  input  logic              rst_n,
  input  afp_pkg::geo_req_t req,
  output afp_pkg::geo_rsp_t rsp
);
  typedef enum logic [4:0] {
    G_IDLE = 5'b00001,
    G_SQRT = 5'b00010,
    G_DIV  = 5'b00100,
    G_CORD = 5'b01000,
    G_DONE = 5'b10000
  } gst_t;

  gst_t st_r, st_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [57:0] rem_r, rem_nxt;
  logic [28:0] root_r, root_nxt;
  logic [57:0] val_r, val_nxt;
  logic [28:0] dq_r, dq_nxt;
  logic [29:0] drem_r, drem_nxt;
  logic [16:0] mg_r;
  logic signed [28:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0] ang_r, ang_nxt;
  logic [12:0] rad_r, rad_nxt;
  logic [33:0] m2;
  logic [30:0] trial;
  logic [29:0] dtrial;
  logic signed [28:0] xs, ys;
  logic signed [16:0] lat_s, lon_s;
  logic [36:0] binprod;

  assign lat_s = $signed(req.lat);
  assign lon_s = $signed(req.lon);
  assign m2 = 34'($signed(lat_s) * $signed(lat_s)) + 34'($signed(lon_s) * $signed(lon_s));
  assign trial = {root_r, 2'b01};
  assign xs = x_r >>> cnt_r[3:0];
  assign ys = y_r >>> cnt_r[3:0];
  assign dtrial = {drem_r[28:0], dq_r[28]};
  assign binprod = {5'd0, ang_r} * 37'(afp_pkg::BINS);

  always_comb begin
    logic [30:0] r2;
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    root_nxt = root_r;
    val_nxt = val_r;
    dq_nxt = dq_r;
    drem_nxt = drem_r;
    x_nxt = x_r;
    y_nxt = y_r;
    ang_nxt = ang_r;
    rad_nxt = rad_r;
    r2 = '0;
    case (st_r)
      G_IDLE: begin
        if (req.start) begin
          st_nxt = G_SQRT;
          cnt_nxt = '0;
          rem_nxt = '0;
          root_nxt = '0;
          val_nxt = {m2, 24'd0};
          if (lat_s < 0) begin
            x_nxt = -(29'(lat_s) <<< 8);
            y_nxt = -(29'(lon_s) <<< 8);
            ang_nxt = 32'h80000000;
          end else begin
            x_nxt = 29'(lat_s) <<< 8;
            y_nxt = 29'(lon_s) <<< 8;
            ang_nxt = '0;
          end
        end
      end
      G_SQRT: begin
        r2 = {rem_r[28:0], val_r[57:56]};
        val_nxt = {val_r[55:0], 2'b00};
        if (r2 >= trial) begin
          rem_nxt = 58'(r2 - trial);
          root_nxt = {root_r[27:0], 1'b1};
        end else begin
          rem_nxt = 58'(r2);
          root_nxt = {root_r[27:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd28) begin
          st_nxt = G_DIV;
          cnt_nxt = '0;
          dq_nxt = root_nxt;
          drem_nxt = '0;
        end
      end
      G_DIV: begin
        dq_nxt = {dq_r[27:0], 1'b0};
        if (dtrial >= 30'(mg_r)) begin
          drem_nxt = dtrial - 30'(mg_r);
          dq_nxt[0] = 1'b1;
        end else begin
          drem_nxt = dtrial;
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd28) begin
          rad_nxt = (dq_nxt > 29'(afp_pkg::R_ONE)) ? afp_pkg::R_ONE : dq_nxt[12:0];
          st_nxt = G_CORD;
          cnt_nxt = '0;
        end
      end
      G_CORD: begin
        if (y_r == 0 || cnt_r == 6'(afp_pkg::CORDIC_STEPS)) begin
          st_nxt = G_DONE;
        end else begin
          if (y_r > 0) begin
            x_nxt = x_r + ys;
            y_nxt = y_r - xs;
            ang_nxt = ang_r + afp_pkg::atan_turn(cnt_r[3:0]);
          end else begin
            x_nxt = x_r - ys;
            y_nxt = y_r + xs;
            ang_nxt = ang_r - afp_pkg::atan_turn(cnt_r[3:0]);
          end
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      G_DONE: st_nxt = G_IDLE;
      default: st_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= G_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    if (st_r == G_IDLE && req.start) begin
      mg_r <= req.mg;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    root_r <= root_nxt;
    val_r <= val_nxt;
    dq_r <= dq_nxt;
    drem_r <= drem_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    ang_r <= ang_nxt;
    rad_r <= rad_nxt;
  end

  assign rsp.done = (st_r == G_DONE);
  assign rsp.radius = rad_r;
  assign rsp.bin = binprod[32 +: afp_pkg::BIN_W];
endmodule

FILE: rtl/accel_follow_and_polar_peak_hold.sv
// channel | ports                         | payload
// in      | in_valid, in_ready, in_word   | in_word_t
// out     | out_valid, out_ready, out_word| out_word_t
// cfg     | cfg_psel .. cfg_pready        | max_g at address 0
// a sample first moves the display point, then runs 29 square-root steps, 29 divide
// steps and up to 16 angle steps in the geometry unit; if the radius is above R_MIN,
// it then reads the bin ram and writes the bin if the new radius is larger
// a read gives its word after a bin ram read; an unused code gives it in the next cycle
// a clear zeroes the 32 bins one per cycle and gives its word after the last bin;
// the same pass runs after reset before the first word is taken
// the output register holds one word; in_ready drops while a result waits
`include "accel_follow_and_polar_peak_hold_defines.svh"
module accel_follow_and_polar_peak_hold (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  afp_pkg::in_word_t in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output afp_pkg::out_word_t out_word,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [1:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  typedef enum logic [6:0] {
    S_WIPE  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_GEO   = 7'b0000100,
    S_RD    = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_BREAD = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [14:0] max_g_r;
  logic [16:0] mg;
  logic signed [16:0] shown_lat_r, shown_lat_nxt, shown_lon_r, shown_lon_nxt;
  logic signed [16:0] lat_c, lon_c;
  logic signed [17:0] dlat, dlon, dlat_r, dlat_nxt, dlon_r, dlon_nxt;
  logic [35:0] d2;
  logic [15:0] f, f_r, f_nxt;
  logic zero_r, zero_nxt;
  logic [afp_pkg::BIN_W-1:0] wcnt_r, wcnt_nxt;
  logic [afp_pkg::BIN_W-1:0] bin_r, bin_nxt;
  logic [12:0] rad_r, rad_nxt;
  afp_pkg::out_word_t res_r, res_nxt;
  afp_pkg::geo_req_t greq;
  afp_pkg::geo_rsp_t grsp;
  logic we;
  logic [afp_pkg::BIN_W-1:0] waddr, raddr;
  logic [12:0] wdata, rdata;
  logic read_ok_r, read_ok_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {17'd0, max_g_r};
  assign mg = (max_g_r == 15'd0) ? 17'd1 : {2'b00, max_g_r};

  function automatic logic signed [16:0] clampdz(input logic signed [15:0] v,
                                                 input logic [16:0] lim);
    logic signed [16:0] w;
    w = 17'(v);
    if (w > $signed(lim)) w = $signed(lim);
    if (w < -$signed(lim)) w = -$signed(lim);
    if (w > -$signed({1'b0, afp_pkg::DEADZONE_Q}) && w < $signed({1'b0, afp_pkg::DEADZONE_Q}))
      w = '0;
    return w;
  endfunction

  function automatic logic signed [16:0] follow(input logic signed [16:0] s,
      input logic signed [17:0] d, input logic [15:0] f, input logic [16:0] lim);
    logic signed [35:0] p;
    logic signed [19:0] n;
    p = 36'(d) * $signed({20'd0, f}) + 36'sd32768;
    n = 20'(s) + 20'(p >>> 16);
    if (n > $signed({3'b0, lim})) n = $signed({3'b0, lim});
    if (n < -$signed({3'b0, lim})) n = -$signed({3'b0, lim});
    return n[16:0];
  endfunction

  assign lat_c = clampdz(in_word.lat_g, mg);
  assign lon_c = clampdz(in_word.lon_g, mg);

  assign dlat = 18'(lat_c) - 18'(shown_lat_r);
  assign dlon = 18'(lon_c) - 18'(shown_lon_r);
  assign d2 = 36'(dlat * dlat) + 36'(dlon * dlon);
  assign f = (d2 > 36'(afp_pkg::D2_HIGH)) ? afp_pkg::FOLLOW_HIGH :
             (d2 > 36'(afp_pkg::D2_MID)) ? afp_pkg::FOLLOW_MID : afp_pkg::FOLLOW_LOW;

  assign greq.start = (st_r == S_IDLE) && in_valid && in_word.req_type == afp_pkg::REQ_SAMPLE;
  assign greq.mg = mg;
  assign greq.lat = lat_c;
  assign greq.lon = lon_c;

  afp_geom u_geom (.clk(clk), .rst_n(rst_n), .req(greq), .rsp(grsp));

  afp_ram #(.WIDTH(13), .DEPTH(afp_pkg::BINS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_word = res_r;

  always_comb begin
    st_nxt = st_r;
    wcnt_nxt = wcnt_r;
    bin_nxt = bin_r;
    rad_nxt = rad_r;
    res_nxt = res_r;
    read_ok_nxt = read_ok_r;
    shown_lat_nxt = shown_lat_r;
    shown_lon_nxt = shown_lon_r;
    dlat_nxt = dlat_r;
    dlon_nxt = dlon_r;
    f_nxt = f_r;
    zero_nxt = zero_r;
    we = 1'b0;
    waddr = bin_r;
    wdata = rad_r;
    raddr = bin_r;
    case (st_r)
      S_WIPE: begin
        we = 1'b1;
        waddr = wcnt_r;
        wdata = '0;
        wcnt_nxt = wcnt_r + 1'b1;
        if (wcnt_r == afp_pkg::BIN_LAST) begin
          st_nxt = read_ok_r ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          case (in_word.req_type)
            afp_pkg::REQ_SAMPLE: begin
              dlat_nxt = dlat;
              dlon_nxt = dlon;
              f_nxt = f;
              zero_nxt = (lat_c == '0) && (lon_c == '0);
              st_nxt = S_UPD;
            end
            afp_pkg::REQ_READ: begin
              raddr = in_word.read_bin[afp_pkg::BIN_W-1:0];
              read_ok_nxt = 32'(in_word.read_bin) < afp_pkg::BINS;
              res_nxt.bin_slot = in_word.read_bin;
              res_nxt.display_lat = shown_lat_r[15:0];
              res_nxt.display_lon = shown_lon_r[15:0];
              st_nxt = S_BREAD;
            end
            afp_pkg::REQ_CLEAR: begin
              shown_lat_nxt = '0;
              shown_lon_nxt = '0;
              wcnt_nxt = '0;
              read_ok_nxt = 1'b1;
              st_nxt = S_WIPE;
            end
            default: begin
              res_nxt.display_lat = shown_lat_r[15:0];
              res_nxt.display_lon = shown_lon_r[15:0];
              st_nxt = S_OUT;
            end
          endcase
        end
      end
      S_UPD: begin
        if (zero_r) begin
          shown_lat_nxt = '0;
          shown_lon_nxt = '0;
        end else begin
          shown_lat_nxt = follow(shown_lat_r, dlat_r, f_r, mg);
          shown_lon_nxt = follow(shown_lon_r, dlon_r, f_r, mg);
        end
        st_nxt = S_GEO;
      end
      S_GEO: begin
        res_nxt.display_lat = shown_lat_r[15:0];
        res_nxt.display_lon = shown_lon_r[15:0];
        if (grsp.done) begin
          bin_nxt = grsp.bin;
          rad_nxt = grsp.radius;
          raddr = grsp.bin;
          st_nxt = (grsp.radius <= afp_pkg::R_MIN) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        res_nxt.bin_slot = 5'(bin_r);
        if (rdata < rad_r) begin
          we = 1'b1;
          res_nxt.bin_radius = rad_r;
          res_nxt.bin_updated = 1'b1;
        end else begin
          res_nxt.bin_radius = rdata;
        end
        st_nxt = S_OUT;
      end
      S_BREAD: begin
        res_nxt.bin_radius = read_ok_r ? rdata : 13'd0;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_WIPE;
      wcnt_r <= '0;
      max_g_r <= afp_pkg::MAX_G_RST;
      shown_lat_r <= '0;
      shown_lon_r <= '0;
      res_r <= '0;
      read_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      wcnt_r <= wcnt_nxt;
      shown_lat_r <= shown_lat_nxt;
      shown_lon_r <= shown_lon_nxt;
      res_r <= res_nxt;
      read_ok_r <= read_ok_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == afp_pkg::ADDR_MAX_G) begin
        max_g_r <= cfg_pwdata[14:0];
      end
    end
    bin_r <= bin_nxt;
    rad_r <= rad_nxt;
    dlat_r <= dlat_nxt;
    dlon_r <= dlon_nxt;
    f_r <= f_nxt;
    zero_r <= zero_nxt;
  end

  `AFP_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !out_valid)
  `AFP_ASSERT_IMPL(a_shown_lim, clk, rst_n, st_r == S_GEO,
                   shown_lat_r <= $signed(mg) && shown_lat_r >= -$signed(mg))
  `AFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))
  `AFP_ASSERT_IMPL(a_rad_max, clk, rst_n, out_valid, out_word.bin_radius <= afp_pkg::R_ONE)
endmodule

FILE: test/tb_accel_follow_and_polar_peak_hold.sv
module tb_accel_follow_and_polar_peak_hold;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  afp_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  afp_pkg::out_word_t out_word;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  accel_follow_and_polar_peak_hold uut (.*);

  always #4 clk = ~clk;

  // predictor state
  longint cur_max_g = 8192;
  longint shown_lat = 0;
  longint shown_lon = 0;
  logic [12:0] peak_mem [afp_pkg::BINS];
  afp_pkg::out_word_t pending_words [$];
  int mismatches = 0;
  bit no_idle = 1'b0;

  initial for (int i = 0; i < afp_pkg::BINS; i++) peak_mem[i] = '0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int angle_to_bin(longint lat, longint lon);
    longint x, y, nx;
    logic [31:0] ang;
    longint unsigned prod;
    x = lat * 256;
    y = lon * 256;
    ang = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h80000000;
    end
    for (int i = 0; i < afp_pkg::CORDIC_STEPS; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang += afp_pkg::atan_turn(4'(i));
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang -= afp_pkg::atan_turn(4'(i));
      end
      x = nx;
    end
    prod = (64'(ang) * afp_pkg::BINS) >> 32;
    return (prod >= afp_pkg::BINS) ? afp_pkg::BINS - 1 : int'(prod);
  endfunction

  function automatic longint clamp_g(longint v, longint lim);
    return (v < -lim) ? -lim : ((v > lim) ? lim : v);
  endfunction

  function automatic afp_pkg::out_word_t predict_display(afp_pkg::in_word_t w);
    longint mg, lat, lon, dlat, dlon, f, d2;
    longint unsigned r;
    int b;
    afp_pkg::out_word_t o;
    o = '0;
    mg = (cur_max_g == 0) ? 1 : cur_max_g;
    if (w.req_type == afp_pkg::REQ_READ) begin
      o.display_lat = shown_lat[15:0];
      o.display_lon = shown_lon[15:0];
      o.bin_slot = w.read_bin;
      o.bin_radius = peak_mem[w.read_bin];
      return o;
    end
    if (w.req_type == afp_pkg::REQ_CLEAR) begin
      shown_lat = 0;
      shown_lon = 0;
      for (int i = 0; i < afp_pkg::BINS; i++) peak_mem[i] = '0;
      return o;
    end
    lat = clamp_g(longint'(w.lat_g), mg);
    lon = clamp_g(longint'(w.lon_g), mg);
    if (lat > -62 && lat < 62) lat = 0;
    if (lon > -62 && lon < 62) lon = 0;
    if (lat == 0 && lon == 0) begin
      shown_lat = 0;
      shown_lon = 0;
    end else begin
      dlat = lat - shown_lat;
      dlon = lon - shown_lon;
      d2 = dlat * dlat + dlon * dlon;
      f = afp_pkg::FOLLOW_LOW;
      if (d2 > afp_pkg::D2_HIGH) f = afp_pkg::FOLLOW_HIGH;
      else if (d2 > afp_pkg::D2_MID) f = afp_pkg::FOLLOW_MID;
      shown_lat = clamp_g(shown_lat + ((dlat * f + 32768) >>> 16), mg);
      shown_lon = clamp_g(shown_lon + ((dlon * f + 32768) >>> 16), mg);
    end
    o.display_lat = shown_lat[15:0];
    o.display_lon = shown_lon[15:0];
    r = int_sqrt(longint'(lat * lat + lon * lon) << 24) / mg;
    if (r > afp_pkg::R_ONE) r = afp_pkg::R_ONE;
    if (r <= afp_pkg::R_MIN) return o;
    b = angle_to_bin(lat, lon);
    if (peak_mem[b] < r) begin
      peak_mem[b] = r[12:0];
      o.bin_updated = 1'b1;
    end
    o.bin_slot = b[4:0];
    o.bin_radius = peak_mem[b];
    return o;
  endfunction

  function automatic afp_pkg::in_word_t mk_word(logic [1:0] req, int lat, int lon, int rb);
    afp_pkg::in_word_t w;
    w.req_type = req;
    w.lat_g = lat[15:0];
    w.lon_g = lon[15:0];
    w.read_bin = rb[4:0];
    return w;
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // result side: random stalls and checking
  always @(posedge clk) begin
    afp_pkg::out_word_t e;
    out_ready <= no_idle || ($urandom_range(99) >= 6);
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        note_mismatch($sformatf("unexpected word %h", out_word));
      end else begin
        e = pending_words.pop_front();
        if (out_word.display_lat !== e.display_lat)
          note_mismatch($sformatf("display_lat exp %0d got %0d", e.display_lat,
                                  out_word.display_lat));
        if (out_word.display_lon !== e.display_lon)
          note_mismatch($sformatf("display_lon exp %0d got %0d", e.display_lon,
                                  out_word.display_lon));
        if (out_word.bin_slot !== e.bin_slot)
          note_mismatch($sformatf("bin_slot exp %0d got %0d", e.bin_slot,
                                  out_word.bin_slot));
        if (out_word.bin_radius !== e.bin_radius)
          note_mismatch($sformatf("bin_radius exp %0d got %0d", e.bin_radius,
                                  out_word.bin_radius));
        if (out_word.bin_updated !== e.bin_updated)
          note_mismatch($sformatf("bin_updated exp %0d got %0d", e.bin_updated,
                                  out_word.bin_updated));
      end
    end
  end

  task automatic send_word(afp_pkg::in_word_t w);
    if (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    pending_words.push_back(predict_display(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_g(int v);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= afp_pkg::ADDR_MAX_G;
    cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[14:0] !== v[14:0])
      note_mismatch($sformatf("max_g readback exp %0d got %0d", v, cfg_prdata[14:0]));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cur_max_g = v & 16'h7FFF;
    @(posedge clk);
  endtask

  function automatic int rand_axis();
    case ($urandom_range(3))
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(400)) - 200;
      default: return int'($urandom_range(16000)) - 8000;
    endcase
  endfunction

  task automatic test_directed();
    send_word(mk_word(afp_pkg::REQ_READ, 0, 0, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 32767, 0, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, -32768, 0, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 0, 32767, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 0, -32768, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, -32768, -32768, 31));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 61, -61, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 0, 0, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 62, -62, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 100, 50, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 4096, 4096, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 1500, -200, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, -3000, 3000, 0));
    send_word(mk_word(afp_pkg::REQ_READ, 0, 0, 31));
    send_word(mk_word(afp_pkg::REQ_READ, -1, -1, 16));
    send_word(mk_word(afp_pkg::REQ_CLEAR, 0, 0, 0));
    send_word(mk_word(afp_pkg::REQ_READ, 0, 0, 16));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 8192, 0, 0));
    send_word(mk_word(afp_pkg::REQ_SAMPLE, 8192, 0, 0));
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 2)
        send_word(mk_word(afp_pkg::REQ_CLEAR, rand_axis(), rand_axis(), $urandom_range(31)));
      else if (k < 18)
        send_word(mk_word(afp_pkg::REQ_READ, rand_axis(), rand_axis(), $urandom_range(31)));
      else
        send_word(mk_word(afp_pkg::REQ_SAMPLE, rand_axis(), rand_axis(), $urandom_range(31)));
    end
  endtask

  task automatic test_max_g_settings();
    write_max_g(256);
    test_random(120);
    write_max_g(32767);
    test_directed();
    test_random(120);
    write_max_g(8192);
  endtask

  task automatic test_no_idle_stretch();
    no_idle = 1'b1;
    test_random(150);
    no_idle = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    test_random(100);
    wait_drained();
    test_random(100);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_max_g_settings();
    test_no_idle_stretch();
    test_pause_until_drained();
    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end
endmodule
